FILE: hdl/assert_macros.svh
// Assertion helpers for the subframe decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define GLSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define GLSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/glsd_pkg.sv
`timescale 1ns / 1ps

package glsd_pkg;

  localparam int NAV_WORDS = 10;
  localparam int WORD_W    = 30;
  localparam int WADDR_W   = 4;

  localparam logic [7:0]         PREAMBLE  = 8'd139;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NAV_WORDS - 1);

  localparam logic [4:0] SF1_FIRST = 5'd0;
  localparam logic [4:0] SF1_LAST  = 5'd10;
  localparam logic [4:0] SF2_FIRST = 5'd11;
  localparam logic [4:0] SF2_LAST  = 5'd19;
  localparam logic [4:0] SF3_FIRST = 5'd20;
  localparam logic [4:0] SF3_LAST  = 5'd28;

  typedef enum logic [1:0] {
    ST_FIELD        = 2'd0,
    ST_BAD_PREAMBLE = 2'd1,
    ST_BAD_SID      = 2'd2,
    ST_NO_EPH       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic [WADDR_W-1:0] wa;
    logic [4:0]         la;
    logic [4:0]         ha;
    logic [WADDR_W-1:0] wb;
    logic [4:0]         lb;
    logic [4:0]         hb;
    logic               sgn;
  } field_desc_t;

  function automatic field_desc_t field_desc(input logic [4:0] idx);
    field_desc_t fd;
    case (idx)
      5'd0:    fd = '{4'd2, 5'd10, 5'd2,  4'd0, 5'd0, 5'd0, 1'b0};
      5'd1:    fd = '{4'd2, 5'd2,  5'd12, 4'd0, 5'd0, 5'd0, 1'b0};
      5'd2:    fd = '{4'd2, 5'd4,  5'd14, 4'd0, 5'd0, 5'd0, 1'b0};
      5'd3:    fd = '{4'd2, 5'd6,  5'd18, 4'd0, 5'd0, 5'd0, 1'b0};
      5'd4:    fd = '{4'd3, 5'd2,  5'd24, 4'd7, 5'd8, 5'd2, 1'b0};
      5'd5:    fd = '{4'd3, 5'd1,  5'd2,  4'd0, 5'd0, 5'd0, 1'b0};
      5'd6:    fd = '{4'd6, 5'd8,  5'd18, 4'd0, 5'd0, 5'd0, 1'b1};
      5'd7:    fd = '{4'd7, 5'd16, 5'd10, 4'd0, 5'd0, 5'd0, 1'b0};
      5'd8:    fd = '{4'd8, 5'd8,  5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd9:    fd = '{4'd8, 5'd16, 5'd10, 4'd0, 5'd0, 5'd0, 1'b1};
      5'd10:   fd = '{4'd9, 5'd22, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd11:   fd = '{4'd2, 5'd8,  5'd2,  4'd0, 5'd0, 5'd0, 1'b0};
      5'd12:   fd = '{4'd2, 5'd16, 5'd10, 4'd0, 5'd0, 5'd0, 1'b1};
      5'd13:   fd = '{4'd3, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd14:   fd = '{4'd3, 5'd8,  5'd18, 4'd4, 5'd24, 5'd2, 1'b1};
      5'd15:   fd = '{4'd5, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd16:   fd = '{4'd5, 5'd8,  5'd18, 4'd6, 5'd24, 5'd2, 1'b0};
      5'd17:   fd = '{4'd7, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd18:   fd = '{4'd7, 5'd8,  5'd18, 4'd8, 5'd24, 5'd2, 1'b0};
      5'd19:   fd = '{4'd9, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b0};
      5'd20:   fd = '{4'd9, 5'd8,  5'd2,  4'd0, 5'd0, 5'd0, 1'b0};
      5'd21:   fd = '{4'd2, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd22:   fd = '{4'd2, 5'd8,  5'd18, 4'd3, 5'd24, 5'd2, 1'b1};
      5'd23:   fd = '{4'd4, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd24:   fd = '{4'd4, 5'd8,  5'd18, 4'd5, 5'd24, 5'd2, 1'b1};
      5'd25:   fd = '{4'd6, 5'd16, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd26:   fd = '{4'd6, 5'd8,  5'd18, 4'd7, 5'd24, 5'd2, 1'b1};
      5'd27:   fd = '{4'd8, 5'd24, 5'd2,  4'd0, 5'd0, 5'd0, 1'b1};
      5'd28:   fd = '{4'd9, 5'd14, 5'd10, 4'd0, 5'd0, 5'd0, 1'b1};
      default: fd = '{4'd0, 5'd0,  5'd0,  4'd0, 5'd0, 5'd0, 1'b0};
    endcase
    return fd;
  endfunction

endpackage

FILE: hdl/gps_lnav_subframe_decoder.sv
// Output order: a header-only result (bad preamble, bad ID, subframe 4/5) is registered in the cycle
//   after the tenth word is taken; the first field of subframes 1-3 follows the READ and LOAD states.
// Throughput: one word per cycle while collecting, unless the tenth word waits for a pending output;
//   each field takes a read-then-load pass over the two-read-port word buffer and can wait in LOAD on out_stall.
// Reset: synchronous, active low; clears word count, seen mask, sequencer and output
//   valid. The word buffer is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gps_lnav_subframe_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [29:0]         in_nav_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          out_param_id,
  output logic signed [32:0]  out_param_value,
  output logic [2:0]          out_subframe_id,
  output logic [1:0]          out_status,
  output logic [4:0]          out_seen_mask,
  output logic                out_last_result
);

  glsd_pkg::state_t state_r, state_nxt;

  logic [glsd_pkg::WADDR_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]                   idx_r, idx_nxt;
  logic [4:0]                   last_r, last_nxt;
  logic [2:0]                   sid_r, sid_nxt;
  logic                         pre_ok_r, pre_ok_nxt;
  logic [4:0]                   seen_r, seen_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [4:0]                   out_param_id_r;
  logic [32:0]                  out_param_value_r;
  logic [2:0]                   out_subframe_id_r;
  glsd_pkg::status_t            out_status_r;
  logic [4:0]                   out_seen_mask_r;
  logic                         out_last_result_r;

  logic in_acc, tenth, out_free, hdr_ok, sid_bad, sid_eph, start_fields, ld_hdr, ld_fld;
  glsd_pkg::status_t hdr_status;
  logic [2:0]        hdr_sid;

  glsd_pkg::field_desc_t fd;
  logic [glsd_pkg::WORD_W-1:0] rd_a, rd_b;
  logic [5:0]  sh_a, sh_b, flen;
  logic [32:0] a_bits, b_bits, comb_bits, len_mask, fld_value;
  logic        sign_bit;

  assign fd = glsd_pkg::field_desc(idx_r);

  glsd_word_buf u_buf (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_addr   (cnt_r),
    .wr_data   (in_nav_word),
    .rd_addr_a (fd.wa),
    .rd_addr_b (fd.wb),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign tenth    = (cnt_r == glsd_pkg::LAST_WORD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign sid_bad  = (sid_r == 3'd0) || (sid_r > 3'd5);
  assign sid_eph  = (sid_r <= 3'd3);
  assign hdr_ok   = pre_ok_r && !sid_bad;

  always_comb begin
    sh_a      = 6'd32 - {1'b0, fd.ha} - {1'b0, fd.la};
    sh_b      = 6'd32 - {1'b0, fd.hb} - {1'b0, fd.lb};
    a_bits    = ({3'b000, rd_a} >> sh_a) & ((33'd1 << fd.la) - 33'd1);
    b_bits    = ({3'b000, rd_b} >> sh_b) & ((33'd1 << fd.lb) - 33'd1);
    comb_bits = (a_bits << fd.lb) | b_bits;
    flen      = {1'b0, fd.la} + {1'b0, fd.lb};
    len_mask  = (33'd1 << flen) - 33'd1;
    sign_bit  = |(comb_bits & (33'd1 << (flen - 6'd1)));
    fld_value = (fd.sgn && sign_bit) ? (comb_bits | ~len_mask) : comb_bits;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glsd_pkg::S_COLLECT: begin
        if (in_acc && tenth && hdr_ok && sid_eph) begin
          state_nxt = glsd_pkg::S_READ;
        end
      end
      glsd_pkg::S_READ: begin
        state_nxt = glsd_pkg::S_LOAD;
      end
      glsd_pkg::S_LOAD: begin
        if (out_free) begin
          state_nxt = (idx_r == last_r) ? glsd_pkg::S_COLLECT : glsd_pkg::S_READ;
        end
      end
      default: state_nxt = glsd_pkg::S_COLLECT;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != glsd_pkg::S_COLLECT) || (tenth && out_valid_r);
    start_fields = (state_r == glsd_pkg::S_COLLECT) && in_acc && tenth && hdr_ok && sid_eph;
    ld_hdr       = (state_r == glsd_pkg::S_COLLECT) && in_acc && tenth && !start_fields;
    ld_fld       = (state_r == glsd_pkg::S_LOAD) && out_free;

    if (!pre_ok_r) begin
      hdr_status = glsd_pkg::ST_BAD_PREAMBLE;
      hdr_sid    = 3'd0;
    end else if (sid_bad) begin
      hdr_status = glsd_pkg::ST_BAD_SID;
      hdr_sid    = sid_r;
    end else begin
      hdr_status = glsd_pkg::ST_NO_EPH;
      hdr_sid    = sid_r;
    end

    cnt_nxt    = cnt_r;
    pre_ok_nxt = pre_ok_r;
    sid_nxt    = sid_r;
    seen_nxt   = seen_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;

    if (in_acc) begin
      cnt_nxt = tenth ? '0 : cnt_r + glsd_pkg::WADDR_W'(1);
      if (cnt_r == glsd_pkg::WADDR_W'(0)) begin
        pre_ok_nxt = (in_nav_word[29:22] == glsd_pkg::PREAMBLE);
      end
      if (cnt_r == glsd_pkg::WADDR_W'(1)) begin
        sid_nxt = in_nav_word[10:8];
      end
      if (tenth && hdr_ok) begin
        seen_nxt = seen_r | (5'd1 << (sid_r - 3'd1));
      end
    end

    if (start_fields) begin
      unique case (sid_r)
        3'd1: begin
          idx_nxt  = glsd_pkg::SF1_FIRST;
          last_nxt = glsd_pkg::SF1_LAST;
        end
        3'd2: begin
          idx_nxt  = glsd_pkg::SF2_FIRST;
          last_nxt = glsd_pkg::SF2_LAST;
        end
        default: begin
          idx_nxt  = glsd_pkg::SF3_FIRST;
          last_nxt = glsd_pkg::SF3_LAST;
        end
      endcase
    end else if (ld_fld) begin
      idx_nxt = idx_r + 5'd1;
    end

    out_valid_nxt = (out_valid_r && out_stall) || ld_hdr || ld_fld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glsd_pkg::S_COLLECT;
      cnt_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_ok_r <= pre_ok_nxt;
    sid_r    <= sid_nxt;
    idx_r    <= idx_nxt;
    last_r   <= last_nxt;
    if (ld_hdr) begin
      out_param_id_r    <= 5'd0;
      out_param_value_r <= '0;
      out_subframe_id_r <= hdr_sid;
      out_status_r      <= hdr_status;
      out_seen_mask_r   <= seen_nxt;
      out_last_result_r <= 1'b1;
    end else if (ld_fld) begin
      out_param_id_r    <= idx_r;
      out_param_value_r <= fld_value;
      out_subframe_id_r <= sid_r;
      out_status_r      <= glsd_pkg::ST_FIELD;
      out_seen_mask_r   <= seen_r;
      out_last_result_r <= (idx_r == last_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_param_id    = out_param_id_r;
  assign out_param_value = out_param_value_r;
  assign out_subframe_id = out_subframe_id_r;
  assign out_status      = out_status_r;
  assign out_seen_mask   = out_seen_mask_r;
  assign out_last_result = out_last_result_r;

  `GLSD_ASSERT(a_last_field_returns, clk, rst_n, (ld_fld && idx_r == last_r) |=> (state_r == glsd_pkg::S_COLLECT && out_valid && out_last_result), "last field did not close subframe")
  `GLSD_ASSERT(a_field_id_range, clk, rst_n, (out_valid && out_status == glsd_pkg::ST_FIELD) |-> (out_param_id <= glsd_pkg::SF3_LAST), "field result with bad param_id")
  `GLSD_ASSERT(a_seen_monotonic, clk, rst_n, $past(rst_n) |-> ((seen_r & $past(seen_r)) == $past(seen_r)), "seen mask lost a bit")
  `GLSD_ASSERT(a_busy_stalls_input, clk, rst_n, (state_r != glsd_pkg::S_COLLECT) |-> in_stall, "word taken while decoding")

endmodule

FILE: hdl/glsd_word_buf.sv
`timescale 1ns / 1ps

module glsd_word_buf (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [glsd_pkg::WADDR_W-1:0]      wr_addr,
  input  logic [glsd_pkg::WORD_W-1:0]       wr_data,
  input  logic [glsd_pkg::WADDR_W-1:0]      rd_addr_a,
  input  logic [glsd_pkg::WADDR_W-1:0]      rd_addr_b,
  output logic [glsd_pkg::WORD_W-1:0]       rd_data_a,
  output logic [glsd_pkg::WORD_W-1:0]       rd_data_b
);

  logic [glsd_pkg::WORD_W-1:0] mem [glsd_pkg::NAV_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
